/* hw/rtl/tce_pkg.sv */
// ----------------------------------------------------------------------------
// tce_pkg
// shared types, codes and sizes for the tiny cpu execute stage
// ----------------------------------------------------------------------------
package tce_pkg;

    localparam int REG_COUNT = 8;
    localparam int REG_IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int DATA_W    = 16;
    localparam int DIV_CNT_W = $clog2(DATA_W + 1);

    // opcodes
    localparam logic [3:0] OP_NOP   = 4'd0;
    localparam logic [3:0] OP_HALT  = 4'd1;
    localparam logic [3:0] OP_MOVI  = 4'd2;
    localparam logic [3:0] OP_ADD   = 4'd3;
    localparam logic [3:0] OP_SUB   = 4'd4;
    localparam logic [3:0] OP_DIV   = 4'd5;
    localparam logic [3:0] OP_LOAD  = 4'd6;
    localparam logic [3:0] OP_STORE = 4'd7;
    localparam logic [3:0] OP_JMP   = 4'd8;
    localparam logic [3:0] OP_JZ    = 4'd9;

    // result status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_HALTED     = 3'd1;
    localparam logic [2:0] ST_BAD_INSN   = 3'd2;
    localparam logic [2:0] ST_BAD_REG    = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd4;
    localparam logic [2:0] ST_MISALIGNED = 3'd5;

    typedef struct packed {
        logic        well_formed;
        logic [3:0]  mode;
        logic [3:0]  dest_index;
        logic [3:0]  source_index;
        logic [15:0] immediate_value;
        logic [15:0] target_address;
        logic [15:0] load_data;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        jump_taken;
        logic [15:0] next_pointer;
        logic        memory_read;
        logic        memory_write;
        logic [15:0] access_address;
        logic [15:0] write_data;
        logic        zero_now;
        logic        halted_now;
    } res_t;

    typedef struct packed {
        logic                 en;
        logic [REG_IDX_W-1:0] addr;
        logic [DATA_W-1:0]    data;
    } rf_wr_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] quotient;
    } div_stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_FIN
    } state_t;

    function automatic logic idx_ok(input logic [3:0] idx);
        return {1'b0, idx} < 5'(REG_COUNT);
    endfunction

endpackage

/* hw/rtl/tce_regfile.sv */
// ----------------------------------------------------------------------------
// tce_regfile
// register file, one write port and two registered read ports
// ----------------------------------------------------------------------------
module tce_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tce_pkg::rf_wr_t               wr,
    input  logic [tce_pkg::REG_IDX_W-1:0] ra_addr,
    input  logic [tce_pkg::REG_IDX_W-1:0] rb_addr,
    output logic [tce_pkg::DATA_W-1:0]    ra_data,
    output logic [tce_pkg::DATA_W-1:0]    rb_data
);
    import tce_pkg::*;

    logic [DATA_W-1:0]    mem [REG_COUNT];
    logic [REG_COUNT-1:0] valid_reg;
    logic [DATA_W-1:0]    ra_data_reg;
    logic [DATA_W-1:0]    rb_data_reg;

    // valid bits stand in for the all-zero reset of the entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.en)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        ra_data_reg <= valid_reg[ra_addr] ? mem[ra_addr] : '0;
        rb_data_reg <= valid_reg[rb_addr] ? mem[rb_addr] : '0;
    end

    assign ra_data = ra_data_reg;
    assign rb_data = rb_data_reg;

endmodule

/* hw/rtl/tce_divider.sv */
// ----------------------------------------------------------------------------
// tce_divider
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tce_divider (
    input  logic                clk,
    input  logic                rst_n,
    input  tce_pkg::div_req_t   req,
    output tce_pkg::div_stat_t  stat
);
    import tce_pkg::*;

    logic                 busy_reg;
    logic                 busy_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W-1:0]    quo_reg;
    logic [DATA_W-1:0]    quo_next;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DATA_W-1:0]    dvs_next;
    logic [DATA_W:0]      shifted;
    logic [DATA_W:0]      trial;

    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        trial     = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DATA_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy     = busy_reg;
    assign stat.quotient = quo_reg;

endmodule

/* hw/rtl/tiny_cpu_execute_stage_core.sv */
// ----------------------------------------------------------------------------
// tiny_cpu_execute_stage_core
// execute stage of a small 16-bit cpu: register file, flags and a divider
// ----------------------------------------------------------------------------
// sequence: idle takes the command beat, read fetches the operands, exec checks
// it and writes the result slot; DIV starts the bit-serial divider in exec, waits
// in div until it is done, then finishes; cmd_ready is high only in idle, so a new
// command is taken only after the last one has finished, which waits on a stalled result slot
// reset: asynchronous, active low; registers read as zero, flags cleared,
// no result pending.
module tiny_cpu_execute_stage_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  tce_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output tce_pkg::res_t res
);
    import tce_pkg::*;

    // sequencer
    state_t    state_reg;
    state_t    state_next;

    // captured command beat
    cmd_t      item_reg;

    // architectural flags
    logic      zero_reg;
    logic      zero_next;
    logic      halted_reg;
    logic      halted_next;

    // result slot, parts the sequencer from the consumer
    logic      res_valid_reg;
    logic      res_valid_next;
    res_t      res_reg;

    // register file and divider hookup
    rf_wr_t            rf_wr;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    div_req_t          div_req;
    div_stat_t         div_stat;

    // instruction evaluation
    res_t              result;
    logic              need_div;
    logic              wr_en;
    logic [DATA_W-1:0] wr_val;
    logic              set_halt;

    logic              cmd_fire;
    logic              slot_free;
    logic              finish;

    assign cmd_fire  = cmd_valid && cmd_ready;
    assign slot_free = !res_valid_reg || res_ready;

    tce_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (rf_wr),
        .ra_addr (item_reg.dest_index[REG_IDX_W-1:0]),
        .rb_addr (item_reg.source_index[REG_IDX_W-1:0]),
        .ra_data (opa),
        .rb_data (opb)
    );

    tce_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .stat  (div_stat)
    );

    // decode and evaluate the captured command against operands and flags;
    // errors in order: malformed, bad register, divide by zero, odd address
    always_comb
    begin
        result         = '0;
        need_div       = 1'b0;
        wr_en          = 1'b0;
        wr_val         = '0;
        set_halt       = 1'b0;
        result.status  = ST_OK;
        if (!item_reg.well_formed)
        begin
            result.status = ST_BAD_INSN;
        end
        else
        begin
            case (item_reg.mode)
                OP_NOP:
                begin
                end
                OP_HALT:
                begin
                    set_halt      = 1'b1;
                    result.status = ST_HALTED;
                end
                OP_MOVI:
                begin
                    if (!idx_ok(item_reg.dest_index))
                    begin
                        result.status = ST_BAD_REG;
                    end
                    else
                    begin
                        wr_en  = 1'b1;
                        wr_val = item_reg.immediate_value;
                    end
                end
                OP_ADD, OP_SUB, OP_DIV:
                begin
                    if (!idx_ok(item_reg.dest_index) || !idx_ok(item_reg.source_index))
                    begin
                        result.status = ST_BAD_REG;
                    end
                    else if (item_reg.mode == OP_ADD)
                    begin
                        wr_en  = 1'b1;
                        wr_val = opa + opb;
                    end
                    else if (item_reg.mode == OP_SUB)
                    begin
                        wr_en  = 1'b1;
                        wr_val = opa - opb;
                    end
                    else if (opb == '0)
                    begin
                        result.status = ST_DIV_ZERO;
                    end
                    else
                    begin
                        need_div = 1'b1;
                        wr_en    = 1'b1;
                        wr_val   = div_stat.quotient;
                    end
                end
                OP_LOAD:
                begin
                    if (!idx_ok(item_reg.dest_index))
                    begin
                        result.status = ST_BAD_REG;
                    end
                    else if (item_reg.target_address[0])
                    begin
                        result.status = ST_MISALIGNED;
                    end
                    else
                    begin
                        wr_en                 = 1'b1;
                        wr_val                = item_reg.load_data;
                        result.memory_read    = 1'b1;
                        result.access_address = item_reg.target_address;
                    end
                end
                OP_STORE:
                begin
                    if (!idx_ok(item_reg.source_index))
                    begin
                        result.status = ST_BAD_REG;
                    end
                    else if (item_reg.target_address[0])
                    begin
                        result.status = ST_MISALIGNED;
                    end
                    else
                    begin
                        result.memory_write   = 1'b1;
                        result.access_address = item_reg.target_address;
                        result.write_data     = opb;
                    end
                end
                OP_JMP:
                begin
                    result.jump_taken   = 1'b1;
                    result.next_pointer = item_reg.target_address;
                end
                OP_JZ:
                begin
                    if (zero_reg)
                    begin
                        result.jump_taken   = 1'b1;
                        result.next_pointer = item_reg.target_address;
                    end
                end
                default:
                begin
                    result.status = ST_BAD_INSN;
                end
            endcase
        end
        zero_next         = wr_en ? (wr_val == '0) : zero_reg;
        halted_next       = halted_reg || set_halt;
        result.zero_now   = zero_next;
        result.halted_now = halted_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (need_div)
                begin
                    state_next = S_DIV;
                end
                else if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_DIV:
            begin
                if (!div_stat.busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        cmd_ready        = 1'b0;
        finish           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = opa;
        div_req.divisor  = opb;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
            end
            S_EXEC:
            begin
                div_req.start = need_div;
                finish        = !need_div && slot_free;
            end
            S_FIN:
            begin
                finish = slot_free;
            end
            default:
            begin
            end
        endcase
    end

    // writeback only when the result beat is committed
    assign rf_wr.en   = finish && wr_en;
    assign rf_wr.addr = item_reg.dest_index[REG_IDX_W-1:0];
    assign rf_wr.data = wr_val;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (finish)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            zero_reg      <= 1'b0;
            halted_reg    <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (finish)
            begin
                zero_reg   <= zero_next;
                halted_reg <= halted_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            item_reg <= cmd;
        end
        if (finish)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

/* hw/rtl/tce_checker.sv */
// ----------------------------------------------------------------------------
// tce_checker
// port-level checks for the execute stage, bound to the top level
// ----------------------------------------------------------------------------
module tce_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          cmd_valid,
    input logic          cmd_ready,
    input tce_pkg::cmd_t cmd,
    input logic          res_valid,
    input logic          res_ready,
    input tce_pkg::res_t res
);
    import tce_pkg::*;

    // a waiting command beat holds
    a_cmd_hold: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid && $stable(cmd))
        else $error("command beat changed while waiting");

    // a stalled result beat holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result beat changed while stalled");

    // one command in flight: busy right after a command beat
    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in flight");

    // a halt result always reports the sticky flag
    a_halt_flag: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status == ST_HALTED |-> res.halted_now)
        else $error("halt status without halted flag");

    // pointer is zero unless a jump is taken
    a_ptr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.jump_taken |-> res.next_pointer == '0)
        else $error("next pointer set without jump");

endmodule

bind tiny_cpu_execute_stage_core tce_checker u_tce_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
);

/* verif/tb_tiny_cpu_execute_stage_core.sv */
// ----------------------------------------------------------------------------
// tb_tiny_cpu_execute_stage_core
// self-checking bench for the tiny cpu execute stage: a directed opening that
// walks every opcode and error path, then weighted random instruction streams
// checked against an in-bench model of the register file and flags
// ----------------------------------------------------------------------------
module tb_tiny_cpu_execute_stage_core;

    timeunit 1ns;
    timeprecision 1ps;

    import tce_pkg::*;

    localparam int RAND_ITEMS    = 900;
    localparam int CALM_ITEMS    = 150;   // final stretch with no idling on either side
    localparam int HOLD_AT_ITEM  = 300;   // random item where the long result hold starts
    localparam int HOLD_CYCLES   = 200;
    localparam int STALL_LIMIT   = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = 40;

    // ------------------------------------------------------------------------
    // architectural model: register file, zero and halted flags, plus the
    // queue of results still owed by the block
    // ------------------------------------------------------------------------
    class exec_state_book;
        logic [15:0] regs [REG_COUNT];
        logic        zero_flag;
        logic        halted_flag;
        res_t        owed_results[$];
        int          errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            zero_flag   = 1'b0;
            halted_flag = 1'b0;
            errors      = 0;
        endfunction

        // runs one instruction on the model and returns the result it gives
        function res_t execute_insn(cmd_t c);
            res_t        r;
            logic [15:0] lhs;
            logic [15:0] rhs;
            logic [15:0] wval;
            logic        wr;
            logic        rd_ok;
            logic        rs_ok;
            r      = '0;
            wr     = 1'b0;
            wval   = '0;
            rd_ok  = c.dest_index < REG_COUNT;
            rs_ok  = c.source_index < REG_COUNT;
            r.status = ST_OK;
            if (!c.well_formed) begin
                r.status = ST_BAD_INSN;
            end
            else begin
                case (c.mode)
                    OP_NOP: ;
                    OP_HALT:
                    begin
                        halted_flag = 1'b1;
                        r.status    = ST_HALTED;
                    end
                    OP_MOVI:
                    begin
                        if (!rd_ok) r.status = ST_BAD_REG;
                        else
                        begin
                            wval = c.immediate_value;
                            wr   = 1'b1;
                        end
                    end
                    OP_ADD, OP_SUB, OP_DIV:
                    begin
                        if (!rd_ok || !rs_ok) r.status = ST_BAD_REG;
                        else
                        begin
                            lhs = regs[c.dest_index];
                            rhs = regs[c.source_index];
                            if (c.mode == OP_ADD) wval = lhs + rhs;
                            else if (c.mode == OP_SUB) wval = lhs - rhs;
                            else if (rhs == 16'd0) r.status = ST_DIV_ZERO;
                            else wval = lhs / rhs;
                            wr = (r.status == ST_OK);
                        end
                    end
                    OP_LOAD:
                    begin
                        if (!rd_ok) r.status = ST_BAD_REG;
                        else if (c.target_address[0]) r.status = ST_MISALIGNED;
                        else
                        begin
                            wval             = c.load_data;
                            wr               = 1'b1;
                            r.memory_read    = 1'b1;
                            r.access_address = c.target_address;
                        end
                    end
                    OP_STORE:
                    begin
                        if (!rs_ok) r.status = ST_BAD_REG;
                        else if (c.target_address[0]) r.status = ST_MISALIGNED;
                        else
                        begin
                            r.memory_write   = 1'b1;
                            r.access_address = c.target_address;
                            r.write_data     = regs[c.source_index];
                        end
                    end
                    OP_JMP:
                    begin
                        r.jump_taken   = 1'b1;
                        r.next_pointer = c.target_address;
                    end
                    OP_JZ:
                    begin
                        if (zero_flag)
                        begin
                            r.jump_taken   = 1'b1;
                            r.next_pointer = c.target_address;
                        end
                    end
                    default: r.status = ST_BAD_INSN;
                endcase
            end
            if (wr)
            begin
                regs[c.dest_index] = wval;
                zero_flag          = (wval == 16'd0);
            end
            r.zero_now   = zero_flag;
            r.halted_now = halted_flag;
            return r;
        endfunction

        function void note_insn(cmd_t c);
            owed_results.push_back(execute_insn(c));
        endfunction

        function int owed();
            return owed_results.size();
        endfunction

        task report_mismatch(string what, logic [15:0] got, logic [15:0] want);
            $display("%0t mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
            errors++;
        endtask

        task cmp_field(string what, logic [15:0] got, logic [15:0] want);
            if (got !== want) report_mismatch(what, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            if (owed_results.size() == 0)
            begin
                report_mismatch("result beat with nothing owed", got.status, '0);
                return;
            end
            want = owed_results.pop_front();
            cmp_field("status", got.status, want.status);
            cmp_field("jump_taken", got.jump_taken, want.jump_taken);
            cmp_field("next_pointer", got.next_pointer, want.next_pointer);
            cmp_field("memory_read", got.memory_read, want.memory_read);
            cmp_field("memory_write", got.memory_write, want.memory_write);
            cmp_field("access_address", got.access_address, want.access_address);
            cmp_field("write_data", got.write_data, want.write_data);
            cmp_field("zero_now", got.zero_now, want.zero_now);
            cmp_field("halted_now", got.halted_now, want.halted_now);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and block hookup
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_ready;
    cmd_t cmd = '0;
    logic res_valid;
    logic res_ready = 1'b0;
    res_t res;

    exec_state_book book = new();

    // idling switch and long-hold request, both written by the stimulus process
    logic gaps_on = 1'b1;
    int   hold_asked = 0;

    initial
    begin
        forever #2 clk = ~clk;
    end

    tiny_cpu_execute_stage_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // ------------------------------------------------------------------------
    // beat monitor and watchdog: everything sampled on the rising edge, so the
    // values seen are the ones present just before the edge
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            // result first: a result beat always belongs to an older command
            if (res_valid && res_ready) book.check_result(res);
            if (cmd_valid && cmd_ready) book.note_insn(cmd);
            if ((res_valid && res_ready) || (cmd_valid && cmd_ready)) quiet_cycles = 0;
            else quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // result side: random bursts of backpressure, plus one long hold on request
    // so the block sits full while commands keep arriving
    // ------------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int hold_served;
        hold_left   = 0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                hold_left   = HOLD_CYCLES - 1;
                res_ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                res_ready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 4) == 0)
            begin
                hold_left = $urandom_range(1, 7) - 1;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // command side
    // ------------------------------------------------------------------------

    // offers one command beat, maybe after an idle burst, and returns on the
    // edge where it is taken; valid stays high into the next call unless a
    // burst drops it
    task automatic send_cmd(input cmd_t c);
        int idle;
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            idle = $urandom_range(1, 7);
            cmd_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
    endtask

    function automatic cmd_t make_insn(logic wf, logic [3:0] op, logic [3:0] rd,
                                       logic [3:0] rs, logic [15:0] imm,
                                       logic [15:0] addr, logic [15:0] ld);
        cmd_t c;
        c.well_formed     = wf;
        c.mode            = op;
        c.dest_index      = rd;
        c.source_index    = rs;
        c.immediate_value = imm;
        c.target_address  = addr;
        c.load_data       = ld;
        return c;
    endfunction

    // mostly legal register indexes, sometimes out of range
    function automatic logic [3:0] rand_index();
        if ($urandom_range(0, 9) == 0) return 4'($urandom_range(REG_COUNT, 15));
        return 4'($urandom_range(0, REG_COUNT - 1));
    endfunction

    // weighted random instruction: mostly well-formed work that changes
    // state, small values often so divides and zero results come up
    function automatic cmd_t rand_insn();
        cmd_t c;
        int   pick;
        c.well_formed    = 1'b1;
        c.dest_index     = rand_index();
        c.source_index   = rand_index();
        c.target_address = 16'($urandom);
        if ($urandom_range(0, 4) != 0) c.target_address[0] = 1'b0;
        c.load_data = ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom);
        case ($urandom_range(0, 9))
            0:       c.immediate_value = 16'd0;
            1, 2, 3: c.immediate_value = 16'($urandom_range(1, 15));
            default: c.immediate_value = 16'($urandom);
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 4)       c.mode = OP_NOP;
        else if (pick < 7)  c.mode = OP_HALT;
        else if (pick < 27) c.mode = OP_MOVI;
        else if (pick < 37) c.mode = OP_ADD;
        else if (pick < 45) c.mode = OP_SUB;
        else if (pick < 57) c.mode = OP_DIV;
        else if (pick < 69) c.mode = OP_LOAD;
        else if (pick < 79) c.mode = OP_STORE;
        else if (pick < 84) c.mode = OP_JMP;
        else if (pick < 91) c.mode = OP_JZ;
        else if (pick < 95) c.mode = 4'($urandom_range(10, 15));
        else
        begin
            // malformed beat with any opcode
            c.well_formed = 1'b0;
            c.mode        = 4'($urandom_range(0, 15));
        end
        return c;
    endfunction

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening: every opcode, error order and flag corner
        send_cmd(make_insn(1'b1, OP_NOP,   4'd0, 4'd0, 16'hA5A5, 16'h5A5A, 16'h1234));
        // jz with the zero flag still clear falls through
        send_cmd(make_insn(1'b1, OP_JZ,    4'd0, 4'd0, 16'h0, 16'h1234, 16'h0));
        send_cmd(make_insn(1'b1, OP_HALT,  4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
        // halt again while halted, later beats still run
        send_cmd(make_insn(1'b1, OP_HALT,  4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_MOVI,  4'd0, 4'd0, 16'hFFFF, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_MOVI,  4'd1, 4'd0, 16'h0001, 16'h0, 16'h0));
        // add wraps to zero and sets the flag, then jz is taken
        send_cmd(make_insn(1'b1, OP_ADD,   4'd0, 4'd1, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_JZ,    4'd0, 4'd0, 16'h0, 16'hFFFE, 16'h0));
        // sub borrows back to all ones
        send_cmd(make_insn(1'b1, OP_SUB,   4'd0, 4'd1, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_MOVI,  4'd7, 4'd0, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_DIV,   4'd0, 4'd7, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_MOVI,  4'd2, 4'd0, 16'h00FF, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_DIV,   4'd0, 4'd2, 16'h0, 16'h0, 16'h0));
        // bad register wins over divide by zero
        send_cmd(make_insn(1'b1, OP_DIV,   4'd8, 4'd7, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_ADD,   4'd0, 4'd15, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, OP_LOAD,  4'd3, 4'd0, 16'h0, 16'hFFFE, 16'h0));
        send_cmd(make_insn(1'b1, OP_LOAD,  4'd3, 4'd0, 16'h0, 16'h0001, 16'hBEEF));
        // bad register wins over odd address
        send_cmd(make_insn(1'b1, OP_LOAD,  4'd15, 4'd0, 16'h0, 16'hFFFF, 16'hBEEF));
        send_cmd(make_insn(1'b1, OP_STORE, 4'd0, 4'd0, 16'h0, 16'hFFFE, 16'h0));
        send_cmd(make_insn(1'b1, OP_STORE, 4'd0, 4'd1, 16'h0, 16'hFFFF, 16'h0));
        send_cmd(make_insn(1'b1, OP_STORE, 4'd0, 4'd8, 16'h0, 16'h0001, 16'h0));
        send_cmd(make_insn(1'b1, OP_JMP,   4'd0, 4'd0, 16'h0, 16'hFFFF, 16'h0));
        // malformed beat with an otherwise legal movi, then undefined opcodes
        send_cmd(make_insn(1'b0, OP_MOVI,  4'd4, 4'd0, 16'h1111, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, 4'd10,    4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
        send_cmd(make_insn(1'b1, 4'd15,    4'd15, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF));

        // random streams; one long result hold mid-run, calm tail at the end
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == HOLD_AT_ITEM) hold_asked <= hold_asked + 1;
            if (i == RAND_ITEMS - CALM_ITEMS) gaps_on <= 1'b0;
            send_cmd(rand_insn());
        end
        cmd_valid <= 1'b0;

        // drain, then linger in case the block sends anything extra
        while (book.owed() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (book.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
